// ===== hdl/ffca_pkg.sv =====
// Package for the first-fit coalescing allocator.
// Holds the transfer payload types and the command and status codes.
// Depends on nothing; used by the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package ffca_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ALIGN = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;

  typedef struct packed {
    logic        command;
    logic [12:0] request_size;
    logic [11:0] block_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] payload_offset;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/ffca_hdr_mem.sv =====
// Block header store: payload size and next free block, one entry per granule.
// Single read port with registered data and one write port with a separate enable per field.
// Depends on nothing but the clock and reset it is given.
`timescale 1ns / 1ps
`default_nettype none

module ffca_hdr_mem #(
  parameter int DEPTH     = 512,
  parameter int IDX_W     = 10,
  parameter int SIZE_W    = 13,
  parameter int INIT_SIZE = 4080
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output logic      [SIZE_W-1:0] rd_size,
  output logic      [IDX_W-1:0]  rd_next,
  input  wire logic              wr_size_en,
  input  wire logic              wr_next_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire logic [SIZE_W-1:0] wr_size,
  input  wire logic [IDX_W-1:0]  wr_next
);

  localparam int AW = $clog2(DEPTH);

  logic [SIZE_W-1:0] size_mem [DEPTH];
  logic [IDX_W-1:0]  next_mem [DEPTH];
  logic [SIZE_W-1:0] size_q_r;
  logic [IDX_W-1:0]  next_q_r;
  // Entry 0 holds the whole page after reset until it is first written.
  logic              sz0_init_r;
  logic              nx0_init_r;
  logic              sz0_sel_r;
  logic              nx0_sel_r;

  always_ff @(posedge clk) begin
    if (wr_size_en) begin
      size_mem[wr_addr[AW-1:0]] <= wr_size;
    end
    if (wr_next_en) begin
      next_mem[wr_addr[AW-1:0]] <= wr_next;
    end
    if (rd_en) begin
      size_q_r <= size_mem[rd_addr[AW-1:0]];
      next_q_r <= next_mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sz0_init_r <= 1'b1;
      nx0_init_r <= 1'b1;
      sz0_sel_r  <= 1'b0;
      nx0_sel_r  <= 1'b0;
    end else begin
      if (wr_size_en && wr_addr == '0) begin
        sz0_init_r <= 1'b0;
      end
      if (wr_next_en && wr_addr == '0) begin
        nx0_init_r <= 1'b0;
      end
      if (rd_en) begin
        sz0_sel_r <= sz0_init_r && rd_addr == '0;
        nx0_sel_r <= nx0_init_r && rd_addr == '0;
      end
    end
  end

  assign rd_size = sz0_sel_r ? SIZE_W'(INIT_SIZE) : size_q_r;
  assign rd_next = nx0_sel_r ? IDX_W'(DEPTH) : next_q_r;

endmodule

`default_nettype wire

// ===== hdl/first_fit_coalescing_allocator.sv =====
// First-fit free-list allocator with coalescing, top level.
// Depends on ffca_pkg and ffca_hdr_mem.
//
// The block manages one page as an address-ordered list of free blocks.
// Requests arrive as in_item transfers (valid/stall); each gives exactly
// one out_item transfer carrying a status and, for a successful allocate,
// the payload byte offset.
//
// Sequence: an allocate reads headers in S_A_RD and S_A_CHK, writes the
// split and taken headers in S_A_WSPL and S_A_WPTR if it splits, relinks in
// S_A_LINK and loads the result in S_FIN. A free walks the list through
// S_F_WALK and S_F_WNXT per header, reads and merges headers in S_F_RCUR,
// S_F_RPTR, S_F_RPRV, S_F_WCUR and S_F_WPRV, then loads the result in S_FIN.
// A misaligned size or malformed free goes straight to S_FIN. The single
// header memory read port sets this pace. Only one request is in flight;
// in_stall is high from acceptance until the result is in the output register.
//
// At reset the whole page is one free block at granule 0; no clearing
// pass is needed. A result waiting under out_stall does not block the next
// request from being accepted, but that request cannot complete until the
// output register has been emptied.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_coalescing_allocator #(
  parameter int PAGE_BYTES    = 4096,
  parameter int GRANULE_BYTES = 8,
  parameter int HEADER_BYTES  = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ffca_pkg::in_item_t in_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ffca_pkg::out_item_t   out_item
);

  localparam int NUM_GRAN = PAGE_BYTES / GRANULE_BYTES;
  localparam int IDX_W    = $clog2(NUM_GRAN) + 1;
  localparam int SIZE_W   = $clog2(PAGE_BYTES) + 1;
  localparam int SUM_W    = SIZE_W + 2;
  localparam int STEP_W   = IDX_W + 1;
  // Granule size is taken to be a power of two.
  localparam int G_SH     = $clog2(GRANULE_BYTES);

  localparam logic [IDX_W-1:0]  NULL_IDX   = IDX_W'(NUM_GRAN);
  localparam logic [STEP_W-1:0] WALK_LIMIT = STEP_W'(NUM_GRAN + 1);
  localparam logic [SUM_W-1:0]  HDR        = SUM_W'(HEADER_BYTES);
  localparam logic [SUM_W-1:0]  GRAN_MASK  = SUM_W'(GRANULE_BYTES - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_A_RD   = 4'd1;
  localparam logic [3:0] S_A_CHK  = 4'd2;
  localparam logic [3:0] S_A_WSPL = 4'd3;
  localparam logic [3:0] S_A_WPTR = 4'd4;
  localparam logic [3:0] S_A_LINK = 4'd5;
  localparam logic [3:0] S_F_WALK = 4'd6;
  localparam logic [3:0] S_F_WNXT = 4'd7;
  localparam logic [3:0] S_F_RCUR = 4'd8;
  localparam logic [3:0] S_F_RPTR = 4'd9;
  localparam logic [3:0] S_F_RPRV = 4'd10;
  localparam logic [3:0] S_F_WCUR = 4'd11;
  localparam logic [3:0] S_F_WPRV = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;

  logic [3:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [IDX_W-1:0]  prev_r, prev_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  link_r, link_nxt;
  logic [IDX_W-1:0]  bn_r, bn_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [SUM_W-1:0]  req_r, req_nxt;
  logic [SUM_W-1:0]  bs_r, bs_nxt;
  logic [SUM_W-1:0]  cs_r, cs_nxt;
  logic [SUM_W-1:0]  ps_r, ps_nxt;
  logic [SUM_W-1:0]  vs_r, vs_nxt;
  ffca_pkg::out_item_t res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  ffca_pkg::out_item_t out_r, out_nxt;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [SIZE_W-1:0] rd_size;
  logic [IDX_W-1:0]  rd_next;
  logic              wr_size_en;
  logic              wr_next_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [SIZE_W-1:0] wr_size;
  logic [IDX_W-1:0]  wr_next;

  ffca_hdr_mem #(
    .DEPTH     (NUM_GRAN),
    .IDX_W     (IDX_W),
    .SIZE_W    (SIZE_W),
    .INIT_SIZE (PAGE_BYTES - HEADER_BYTES)
  ) u_hdr (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_size    (rd_size),
    .rd_next    (rd_next),
    .wr_size_en (wr_size_en),
    .wr_next_en (wr_next_en),
    .wr_addr    (wr_addr),
    .wr_size    (wr_size),
    .wr_next    (wr_next)
  );

  logic              accept;
  logic [SUM_W-1:0]  in_size;
  logic [SUM_W-1:0]  in_offs;
  logic [SUM_W-1:0]  cur_byte_in;
  logic [SUM_W-1:0]  rd_size_w;
  logic [SUM_W-1:0]  ptr_byte;
  logic [SUM_W-1:0]  split_byte;
  logic [SUM_W-1:0]  split_idx;
  logic              merge_next;
  logic              merge_prev;
  logic [SUM_W-1:0]  new_cs;
  logic [IDX_W-1:0]  new_cn;

  assign accept      = in_valid && (state_r == S_IDLE);
  assign in_stall    = (state_r != S_IDLE);
  assign in_size     = SUM_W'(in_item.request_size);
  assign in_offs     = SUM_W'(in_item.block_offset);
  assign cur_byte_in = in_offs - HDR;
  assign rd_size_w   = SUM_W'(rd_size);
  assign ptr_byte    = SUM_W'(ptr_r) << G_SH;
  assign split_byte  = ptr_byte + HDR + req_r;
  assign split_idx   = split_byte >> G_SH;

  // Merge with the following free block, then with the preceding one.
  assign merge_next = (ptr_r != NULL_IDX) &&
                      ((SUM_W'(cur_r) << G_SH) + HDR + cs_r == ptr_byte);
  assign new_cs     = merge_next ? SUM_W'(SIZE_W'(cs_r + HDR + ps_r)) : cs_r;
  assign new_cn     = merge_next ? bn_r : ptr_r;
  assign merge_prev = (prev_r != NULL_IDX) &&
                      ((SUM_W'(prev_r) << G_SH) + HDR + vs_r == (SUM_W'(cur_r) << G_SH));

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    ptr_nxt       = ptr_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    link_nxt      = link_r;
    bn_nxt        = bn_r;
    steps_nxt     = steps_r;
    req_nxt       = req_r;
    bs_nxt        = bs_r;
    cs_nxt        = cs_r;
    ps_nxt        = ps_r;
    vs_nxt        = vs_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = ptr_r;
    wr_size_en    = 1'b0;
    wr_next_en    = 1'b0;
    wr_addr       = ptr_r;
    wr_size       = SIZE_W'(req_r);
    wr_next       = NULL_IDX;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ptr_nxt   = head_r;
          prev_nxt  = NULL_IDX;
          steps_nxt = '0;
          req_nxt   = in_size;
          res_nxt.status         = ffca_pkg::ST_OK;
          res_nxt.payload_offset = '0;
          cur_nxt   = IDX_W'(cur_byte_in >> G_SH);
          if (in_item.command == ffca_pkg::CMD_ALLOC) begin
            if ((in_size & GRAN_MASK) != '0) begin
              res_nxt.status = ffca_pkg::ST_ALIGN;
              state_nxt      = S_FIN;
            end else begin
              state_nxt = S_A_RD;
            end
          end else if (in_offs < HDR || (in_offs & GRAN_MASK) != '0 ||
                       (cur_byte_in >> G_SH) >= SUM_W'(NUM_GRAN)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_F_WALK;
          end
        end
      end

      S_A_RD: begin
        if (ptr_r >= NULL_IDX || steps_r >= WALK_LIMIT) begin
          res_nxt.status = ffca_pkg::ST_NOFIT;
          state_nxt      = S_FIN;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_A_CHK;
        end
      end

      S_A_CHK: begin
        if (rd_size_w >= req_r) begin
          res_nxt.payload_offset = 12'(ptr_byte + HDR);
          bs_nxt = rd_size_w;
          bn_nxt = rd_next;
          if (rd_size_w >= req_r + (HDR << 1) && split_idx < SUM_W'(NUM_GRAN)) begin
            link_nxt  = IDX_W'(split_idx);
            state_nxt = S_A_WSPL;
          end else begin
            link_nxt  = rd_next;
            state_nxt = S_A_LINK;
          end
        end else begin
          prev_nxt  = ptr_r;
          ptr_nxt   = rd_next;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_A_RD;
        end
      end

      S_A_WSPL: begin
        wr_size_en = 1'b1;
        wr_next_en = 1'b1;
        wr_addr    = link_r;
        wr_size    = SIZE_W'(bs_r - req_r - HDR);
        wr_next    = bn_r;
        state_nxt  = S_A_WPTR;
      end

      S_A_WPTR: begin
        wr_size_en = 1'b1;
        wr_next_en = 1'b1;
        wr_addr    = ptr_r;
        wr_size    = SIZE_W'(req_r);
        wr_next    = NULL_IDX;
        state_nxt  = S_A_LINK;
      end

      S_A_LINK: begin
        if (prev_r == NULL_IDX) begin
          head_nxt = link_r;
        end else begin
          wr_next_en = 1'b1;
          wr_addr    = prev_r;
          wr_next    = link_r;
        end
        state_nxt = S_FIN;
      end

      S_F_WALK: begin
        if (ptr_r < NULL_IDX && ptr_r < cur_r && steps_r < WALK_LIMIT) begin
          rd_en     = 1'b1;
          state_nxt = S_F_WNXT;
        end else begin
          if (ptr_r > NULL_IDX) begin
            ptr_nxt = NULL_IDX;
          end
          state_nxt = S_F_RCUR;
        end
      end

      S_F_WNXT: begin
        prev_nxt  = ptr_r;
        ptr_nxt   = rd_next;
        steps_nxt = steps_r + 1'b1;
        state_nxt = S_F_WALK;
      end

      S_F_RCUR: begin
        rd_en     = 1'b1;
        rd_addr   = cur_r;
        state_nxt = S_F_RPTR;
      end

      S_F_RPTR: begin
        cs_nxt = rd_size_w;
        if (ptr_r != NULL_IDX) begin
          rd_en   = 1'b1;
          rd_addr = ptr_r;
        end
        state_nxt = S_F_RPRV;
      end

      S_F_RPRV: begin
        ps_nxt = rd_size_w;
        bn_nxt = rd_next;
        if (prev_r != NULL_IDX) begin
          rd_en   = 1'b1;
          rd_addr = prev_r;
        end
        state_nxt = S_F_WCUR;
      end

      S_F_WCUR: begin
        vs_nxt     = rd_size_w;
        wr_size_en = merge_next;
        wr_next_en = 1'b1;
        wr_addr    = cur_r;
        wr_size    = SIZE_W'(new_cs);
        wr_next    = new_cn;
        cs_nxt     = new_cs;
        link_nxt   = new_cn;
        state_nxt  = S_F_WPRV;
      end

      S_F_WPRV: begin
        wr_addr = prev_r;
        if (merge_prev) begin
          wr_size_en = 1'b1;
          wr_next_en = 1'b1;
          wr_size    = SIZE_W'(vs_r + HDR + cs_r);
          wr_next    = link_r;
        end else if (prev_r == NULL_IDX) begin
          head_nxt = cur_r;
        end else begin
          wr_next_en = 1'b1;
          wr_next    = cur_r;
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A merge with the preceding block adds the size just written to the
  // freed block (cs_r), so a merge on both sides is folded in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    prev_r  <= prev_nxt;
    cur_r   <= cur_nxt;
    link_r  <= link_nxt;
    bn_r    <= bn_nxt;
    steps_r <= steps_nxt;
    req_r   <= req_nxt;
    bs_r    <= bs_nxt;
    cs_r    <= cs_nxt;
    ps_r    <= ps_nxt;
    vs_r    <= vs_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// ===== test/tb_first_fit_coalescing_allocator.sv =====
// Self-checking testbench for the first-fit coalescing allocator.
// Depends on ffca_pkg and first_fit_coalescing_allocator, which also needs ffca_hdr_mem.
`timescale 1ns / 1ps

module tb_first_fit_coalescing_allocator;

  // Geometry of the default instance: a 4 KiB page cut into 8-byte granules.
  localparam int PAGE      = 4096;
  localparam int GRAN      = 8;
  localparam int HDR       = 16;
  localparam int NGRAN     = PAGE / GRAN;
  localparam int NULL_LINK = NGRAN;
  localparam int WALK_MAX  = NGRAN + 1;
  localparam int IDLE_LIMIT = 20000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ffca_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ffca_pkg::out_item_t out_item;

  first_fit_coalescing_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The allocator's own view of the page: block headers indexed by granule.
  logic [12:0] blk_size [NGRAN];
  logic [9:0]  blk_next [NGRAN];
  int          list_head;

  ffca_pkg::out_item_t pending_results[$];
  logic [11:0] live_blocks[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;     // no random idling on either side
  bit          hold_req = 1'b0;  // asks the receiver for a long hold-off

  function automatic int size_of(int idx);
    return idx < NGRAN ? int'(blk_size[idx]) : 0;
  endfunction

  function automatic int next_of(int idx);
    return idx < NGRAN ? int'(blk_next[idx]) : NULL_LINK;
  endfunction

  function automatic void put_size(int idx, int v);
    if (idx < NGRAN) blk_size[idx] = v[12:0];
  endfunction

  function automatic void put_next(int idx, int v);
    if (idx < NGRAN) blk_next[idx] = (v > NULL_LINK) ? NULL_LINK[9:0] : v[9:0];
  endfunction

  function automatic void relink(int prev, int target);
    if (prev == NULL_LINK) list_head = target;
    else put_next(prev, target);
  endfunction

  function automatic void reset_page();
    for (int i = 0; i < NGRAN; i++) begin
      blk_size[i] = '0;
      blk_next[i] = NULL_LINK[9:0];
    end
    blk_size[0] = 13'(PAGE - HDR);
    list_head = 0;
  endfunction

  // Return a block to the list in address order, merging with the free
  // neighbour after it and then with the one before it.
  function automatic void release_block(int offs);
    int cur;
    int cur_byte;
    int ptr;
    int prev;
    int steps;
    ptr = list_head;
    prev = NULL_LINK;
    steps = 0;
    if (offs < HDR || offs % GRAN != 0) return;
    cur_byte = offs - HDR;
    cur = cur_byte / GRAN;
    if (cur >= NGRAN) return;
    while (ptr < NGRAN && ptr < cur && steps < WALK_MAX) begin
      prev = ptr;
      ptr = next_of(ptr);
      steps++;
    end
    if (ptr > NULL_LINK) ptr = NULL_LINK;
    if (ptr != NULL_LINK && cur_byte + HDR + size_of(cur) == ptr * GRAN) begin
      put_size(cur, size_of(cur) + HDR + size_of(ptr));
      put_next(cur, next_of(ptr));
    end else begin
      put_next(cur, ptr);
    end
    if (prev != NULL_LINK && prev * GRAN + HDR + size_of(prev) == cur_byte) begin
      put_size(prev, size_of(prev) + HDR + size_of(cur));
      put_next(prev, next_of(cur));
    end else begin
      relink(prev, cur);
    end
  endfunction

  // First fit: take the first block large enough, splitting off the rest
  // when it can hold a header and a minimum payload.
  function automatic ffca_pkg::out_item_t take_block(int req);
    ffca_pkg::out_item_t r;
    int ptr;
    int prev;
    int steps;
    int bsize;
    int split_idx;
    r.status = ffca_pkg::ST_NOFIT;
    r.payload_offset = '0;
    ptr = list_head;
    prev = NULL_LINK;
    steps = 0;
    if (req % GRAN != 0) begin
      r.status = ffca_pkg::ST_ALIGN;
      return r;
    end
    while (ptr < NGRAN && steps < WALK_MAX) begin
      bsize = size_of(ptr);
      if (bsize >= req) begin
        split_idx = (ptr * GRAN + HDR + req) / GRAN;
        if (bsize >= req + 2 * HDR && split_idx < NGRAN) begin
          put_size(split_idx, bsize - req - HDR);
          put_next(split_idx, next_of(ptr));
          put_size(ptr, req);
          put_next(ptr, NULL_LINK);
          relink(prev, split_idx);
        end else begin
          relink(prev, next_of(ptr));
        end
        r.status = ffca_pkg::ST_OK;
        r.payload_offset = 12'(ptr * GRAN + HDR);
        return r;
      end
      prev = ptr;
      ptr = next_of(ptr);
      steps++;
    end
    return r;
  endfunction

  // Works out the result of an accepted request and keeps the list of live
  // blocks in step, so that frees only ever name blocks that are allocated.
  function automatic void predict(ffca_pkg::in_item_t it);
    ffca_pkg::out_item_t r;
    if (it.command == ffca_pkg::CMD_ALLOC) begin
      r = take_block(int'(it.request_size));
      if (r.status == ffca_pkg::ST_OK) live_blocks.push_back(r.payload_offset);
    end else begin
      release_block(int'(it.block_offset));
      for (int i = 0; i < live_blocks.size(); i++) begin
        if (live_blocks[i] == it.block_offset) begin
          live_blocks.delete(i);
          break;
        end
      end
      r = '0;
    end
    pending_results.push_back(r);
  endfunction

  // Sends one request and holds it until the transfer happens. Valid stays
  // high into the next request unless an idle gap is drawn.
  task automatic send_item(ffca_pkg::in_item_t it);
    in_item = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict(it);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic send_alloc(int req);
    ffca_pkg::in_item_t it;
    it.command = ffca_pkg::CMD_ALLOC;
    it.request_size = 13'(req);
    it.block_offset = 12'($urandom);
    send_item(it);
  endtask

  task automatic send_free(int offs);
    ffca_pkg::in_item_t it;
    it.command = ffca_pkg::CMD_FREE;
    it.request_size = 13'($urandom);
    it.block_offset = 12'(offs);
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // A free of an offset that is neither live nor malformed would read a
  // header that was never written, so only the two safe kinds are made.
  function automatic int malformed_offset();
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, HDR - 1);
      1: return ($urandom_range(2, 511) * GRAN) + $urandom_range(1, GRAN - 1);
      default: return 4095;
    endcase
  endfunction

  function automatic int pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 16) * GRAN;
    if (roll < 80) return $urandom_range(0, 512) * GRAN;
    if (roll < 90) return $urandom_range(0, 4096);
    return PAGE - HDR - $urandom_range(0, 4) * GRAN;
  endfunction

  // Extremes of the fields, zero size, misaligned size, no fit, a whole
  // page taken at once, splits, merging on both sides and malformed frees.
  task automatic test_directed();
    logic [11:0] a;
    logic [11:0] b;
    logic [11:0] c;
    send_alloc(4096);
    send_alloc(7);
    send_alloc(4095);
    send_alloc(PAGE - HDR);
    send_alloc(0);
    send_free(HDR);
    send_alloc(0);
    send_alloc(8);
    send_alloc(64);
    send_alloc(PAGE - HDR - 40);
    a = live_blocks[0];
    b = live_blocks[1];
    c = live_blocks[2];
    send_free(b);
    send_free(a);
    send_free(c);
    send_free(0);
    send_free(HDR - 1);
    send_free(4095);
    send_free(HDR + 3);
    while (live_blocks.size() != 0) send_free(live_blocks[0]);
    send_alloc(PAGE - HDR);
    send_free(live_blocks[0]);
    wait_drained();
  endtask

  task automatic test_random(int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      quiet = (n >= count / 3 && n < count / 3 + 150);
      roll = $urandom_range(0, 99);
      if (roll < 8) send_free(malformed_offset());
      else if (live_blocks.size() != 0 && (roll < 45 || live_blocks.size() > 40))
        send_free(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
      else send_alloc(pick_size());
    end
    quiet = 1'b0;
    wait_drained();
  endtask

  // The receiver holds off while requests keep coming, so the output
  // register fills and the block stalls its input.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int n = 0; n < 12; n++) begin
      if (n % 2 == 0 || live_blocks.size() == 0) send_alloc($urandom_range(0, 8) * GRAN);
      else send_free(live_blocks[0]);
    end
    wait_drained();
  endtask

  // Receiver: random stalls, none in the quiet stretch, and one long
  // hold-off counted here when asked.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall = !quiet && rst_n && $urandom_range(0, 99) < 15;
    end
  end

  // Checks each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d offset=%0d",
                 $time, out_item.status, out_item.payload_offset);
        errors++;
      end else begin
        if (out_item.status !== pending_results[0].status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   pending_results[0].status, out_item.status);
          errors++;
        end
        if (out_item.payload_offset !== pending_results[0].payload_offset) begin
          $display("%0t: payload_offset expected %0d actual %0d", $time,
                   pending_results[0].payload_offset, out_item.payload_offset);
          errors++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Watchdog over cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    reset_page();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random(1100);
    repeat (50) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ffca_pkg.sv
hdl/ffca_hdr_mem.sv
hdl/first_fit_coalescing_allocator.sv
test/tb_first_fit_coalescing_allocator.sv
